// File: src/pmt_pkg.sv
// Shared constants and types for the PS/2 mouse packet tracker.
// No dependencies; imported by pmt_core and ps2_mouse_packet_tracker.
package pmt_pkg;

	// Byte and field constants
	localparam logic [7:0] ACK_BYTE    = 8'hFA;
	localparam logic [7:0] BUTTON_MASK = 8'h07;
	localparam int         BTN_W       = 3;
	localparam int         OUT_POS_W   = 16;
	localparam int         POS_WIDTH_DEF = 16;

	// Packet phase codes
	localparam logic [1:0] PH_WAIT_ACK = 2'd0;
	localparam logic [1:0] PH_BYTE0    = 2'd1;
	localparam logic [1:0] PH_BYTE1    = 2'd2;
	localparam logic [1:0] PH_BYTE2    = 2'd3;

	// One decoded packet
	typedef struct packed {
		logic [BTN_W-1:0]            buttons;
		logic signed [OUT_POS_W-1:0] pos_x;
		logic signed [OUT_POS_W-1:0] pos_y;
	} pmt_result_t;

endpackage

// File: src/pmt_core.sv
// Packet phase tracker and position accumulators for the mouse byte stream.
// Depends on pmt_pkg for phase codes, constants and the result struct.
module pmt_core import pmt_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  mouse_byte,
	output logic        has_result,
	output pmt_result_t result
);

	logic [1:0]                 phase_q;
	logic [BTN_W-1:0]           held_buttons_q;
	logic [7:0]                 held_dx_q;
	logic signed [POS_WIDTH-1:0] pos_x_q;
	logic signed [POS_WIDTH-1:0] pos_y_q;
	logic signed [POS_WIDTH-1:0] pos_x_nxt;
	logic signed [POS_WIDTH-1:0] pos_y_nxt;
	logic [7:0]                 btn_bits;

	// Last byte of a packet closes it
	assign has_result = (phase_q == PH_BYTE2);

	// Position update with 8-bit signed movements, wrapping at POS_WIDTH
	assign pos_x_nxt = pos_x_q + POS_WIDTH'(signed'(held_dx_q));
	assign pos_y_nxt = pos_y_q - POS_WIDTH'(signed'(mouse_byte));
	assign btn_bits  = mouse_byte & BUTTON_MASK;

	// Result: sign-extend or cut to the 16-bit output fields
	always_comb begin
		result.buttons = held_buttons_q;
		result.pos_x   = OUT_POS_W'(pos_x_nxt);
		result.pos_y   = OUT_POS_W'(pos_y_nxt);
	end

	// Phase sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_WAIT_ACK;
			held_buttons_q <= '0;
			held_dx_q      <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
		end else if (fire) begin
			unique case (phase_q)
				PH_WAIT_ACK: begin
					if (mouse_byte == ACK_BYTE) phase_q <= PH_BYTE0;
				end
				PH_BYTE0: begin
					held_buttons_q <= btn_bits[BTN_W-1:0];
					phase_q        <= PH_BYTE1;
				end
				PH_BYTE1: begin
					held_dx_q <= mouse_byte;
					phase_q   <= PH_BYTE2;
				end
				PH_BYTE2: begin
					pos_x_q <= pos_x_nxt;
					pos_y_q <= pos_y_nxt;
					phase_q <= PH_BYTE0;
				end
				default: phase_q <= PH_WAIT_ACK;
			endcase
		end
	end

endmodule

// File: src/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: input register, core, result register.
// Depends on pmt_pkg and pmt_core.
//
// Usage:
//   Byte channel: mouse_byte with byte_valid / byte_stall. A beat is taken at a
//   rising edge with byte_valid high and byte_stall low.
//   Result channel: buttons, pos_x, pos_y with res_valid / res_stall. One result
//   beat per completed three-byte packet; other bytes give no beat.
//   After reset all bytes are dropped until the acknowledge byte 0xFA; then
//   bytes are grouped into packets (buttons, X move, Y move).
//   The result for a packet's last byte is registered: that byte passes the
//   input register, then the result register.
//   Throughput: one byte per cycle while byte_stall is low, set by the
//   phase/position update between the input register and the result register.
//   Reset (arst_n low) clears the phase, held bytes, positions and both
//   valid flags at once.
//   When the receiver stalls, the result register holds; bytes that give no
//   result keep flowing, and a packet's last byte waits in the input register,
//   stalling the byte channel, until the result register frees.
module ps2_mouse_packet_tracker import pmt_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  mouse_byte,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	output logic [BTN_W-1:0]            buttons,
	output logic signed [OUT_POS_W-1:0] pos_x,
	output logic signed [OUT_POS_W-1:0] pos_y,
	output logic                        res_valid,
	input  logic                        res_stall
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        fire;
	logic        has_result;
	logic        byte_take;
	pmt_result_t result;
	pmt_result_t result_q;
	logic        res_valid_q;

	// Stage advances unless it carries a result and the output is blocked
	assign advance    = !has_result || !res_valid_q || !res_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;
	assign byte_take  = byte_valid && !byte_stall;

	pmt_core #(
		.POS_WIDTH(POS_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.mouse_byte(byte_s1),
		.has_result(has_result),
		.result    (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) byte_s1 <= mouse_byte;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && has_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) result_q <= result;
	end

	assign res_valid = res_valid_q;
	assign buttons   = result_q.buttons;
	assign pos_x     = result_q.pos_x;
	assign pos_y     = result_q.pos_y;

endmodule
